@@ hdl/utf8_token_table_checker_assert.svh @@
// assertion macros for the utf8 token table checker
`ifndef UTF8_TOKEN_TABLE_CHECKER_ASSERT_SVH
`define UTF8_TOKEN_TABLE_CHECKER_ASSERT_SVH
`ifndef SYNTHESIS
`define UTC_ASSERT_HOLDS(lbl, expr) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error("utc check failed");
`define UTC_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error("utc check failed");
`else
`define UTC_ASSERT_HOLDS(lbl, expr)
`define UTC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hdl/utf8tc_pkg.sv @@
// shared types and constants for the utf8 token table checker
`timescale 1ns / 1ps
package utf8tc_pkg;

	localparam int MAX_TOKENS       = 1024;
	localparam int MAX_REGION_BYTES = 65536;

	localparam int CNT_W  = 11;
	localparam int RB_W   = 17;
	localparam int BASE_W = 32;
	localparam int IDX_W  = 10;
	localparam int LEN_W  = 3;
	localparam int ADDR_W = 4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TRUNC   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_TRAIL   = 2'd3;

	localparam logic [1:0] REG_TOKEN_COUNT  = 2'd0;
	localparam logic [1:0] REG_REGION_BYTES = 2'd1;
	localparam logic [1:0] REG_REGION_BASE  = 2'd2;

	typedef enum logic [1:0] {
		PH_LEN_LO,
		PH_LEN_HI,
		PH_BODY,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [CNT_W-1:0]  token_count;
		logic [RB_W-1:0]   region_bytes;
		logic [BASE_W-1:0] region_base;
	} cfg_t;

	typedef struct packed {
		logic              token_ready;
		logic [IDX_W-1:0]  token_index;
		logic [BASE_W-1:0] token_offset;
		logic [LEN_W-1:0]  token_length;
		logic              done_res;
		logic [1:0]        status;
	} result_t;

endpackage

@@ hdl/utf8tc_parser.sv @@
// record parser: length prefix, utf8 body check and token bookkeeping
`timescale 1ns / 1ps
module utf8tc_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 clear,
	input  logic [7:0]           in_byte,
	input  utf8tc_pkg::cfg_t     cfg,
	output utf8tc_pkg::result_t res
);
	import utf8tc_pkg::*;

	phase_t           phase_q, phase_d;
	logic [RB_W-1:0]  pos_q, pos_d;
	logic [CNT_W-1:0] seen_q, seen_d;
	logic [7:0]       len_lo_q, len_lo_d;
	logic [LEN_W-1:0] rec_len_q, rec_len_d;
	logic [LEN_W-1:0] body_cnt_q, body_cnt_d;
	logic [7:0]       lead_q, lead_d;
	logic             good_q, good_d;
	logic [1:0]       err_q, err_d;

	logic [CNT_W-1:0] cnt;
	logic [RB_W:0]    rb;
	logic [RB_W:0]    pos1;
	logic [RB_W:0]    rem;
	logic [15:0]      len16;
	logic [LEN_W-1:0] k_next;
	logic             byte_ok;
	logic             good_n;
	logic             tok_fire;
	logic [RB_W:0]    rel_off;

	// clamp the registers to the supported limits
	assign cnt = (cfg.token_count > CNT_W'(MAX_TOKENS)) ? CNT_W'(MAX_TOKENS) : cfg.token_count;
	assign rb  = (cfg.region_bytes > RB_W'(MAX_REGION_BYTES)) ?
		(RB_W+1)'(MAX_REGION_BYTES) : {1'b0, cfg.region_bytes};

	assign pos1    = {1'b0, pos_q} + 1'b1;
	assign len16   = {in_byte, len_lo_q};
	assign rem     = (pos1 <= rb) ? (rb - pos1) : '0;
	assign k_next  = body_cnt_q + 1'b1;
	assign rel_off = pos1 - {{(RB_W+1-LEN_W){1'b0}}, rec_len_q};
	assign good_n  = good_q & byte_ok;

	// utf8 check of the current body byte
	always_comb begin
		byte_ok = 1'b1;
		if (body_cnt_q == '0) begin
			case (rec_len_q)
				3'd1: byte_ok = (in_byte <= 8'h7f);
				3'd2: byte_ok = (in_byte >= 8'hc2) && (in_byte <= 8'hdf);
				3'd3: byte_ok = (in_byte >= 8'he0) && (in_byte <= 8'hef);
				default: byte_ok = (in_byte >= 8'hf0) && (in_byte <= 8'hf4);
			endcase
		end else begin
			if ((in_byte < 8'h80) || (in_byte > 8'hbf)) begin
				byte_ok = 1'b0;
			end
			// second byte narrows the range for overlong, surrogate and cap cases
			if (body_cnt_q == 3'd1) begin
				if (rec_len_q == 3'd3 && lead_q == 8'he0 && in_byte < 8'ha0) byte_ok = 1'b0;
				if (rec_len_q == 3'd3 && lead_q == 8'hed && in_byte > 8'h9f) byte_ok = 1'b0;
				if (rec_len_q == 3'd4 && lead_q == 8'hf0 && in_byte < 8'h90) byte_ok = 1'b0;
				if (rec_len_q == 3'd4 && lead_q == 8'hf4 && in_byte > 8'h8f) byte_ok = 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		seen_d     = seen_q;
		len_lo_d   = len_lo_q;
		rec_len_d  = rec_len_q;
		body_cnt_d = body_cnt_q;
		lead_d     = lead_q;
		good_d     = good_q;
		err_d      = err_q;
		tok_fire   = 1'b0;
		case (phase_q)
			PH_LEN_LO: begin
				pos_d = pos1[RB_W-1:0];
				if (seen_q >= cnt) begin
					phase_d = PH_DONE;
					err_d   = ({1'b0, pos_q} < rb) ? ST_TRAIL : ST_OK;
				end else if (pos1 + 1'b1 > rb) begin
					phase_d = PH_DONE;
					err_d   = ST_TRUNC;
				end else begin
					len_lo_d = in_byte;
					phase_d  = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				pos_d = pos1[RB_W-1:0];
				if (len16 == 16'd0 || len16 > 16'd4 || (RB_W+1)'(len16) > rem) begin
					phase_d = PH_DONE;
					err_d   = ST_INVALID;
				end else begin
					rec_len_d  = len16[LEN_W-1:0];
					body_cnt_d = '0;
					good_d     = 1'b1;
					phase_d    = PH_BODY;
				end
			end
			PH_BODY: begin
				pos_d      = pos1[RB_W-1:0];
				if (body_cnt_q == '0) lead_d = in_byte;
				good_d     = good_n;
				body_cnt_d = k_next;
				if (k_next >= rec_len_q) begin
					if (!good_n) begin
						phase_d = PH_DONE;
						err_d   = ST_INVALID;
					end else begin
						tok_fire = 1'b1;
						seen_d   = seen_q + 1'b1;
						if (seen_d >= cnt) begin
							phase_d = PH_DONE;
							err_d   = (pos1 == rb) ? ST_OK : ST_TRAIL;
						end else if (pos1 + 2'd2 > rb) begin
							phase_d = PH_DONE;
							err_d   = ST_TRUNC;
						end else begin
							phase_d = PH_LEN_LO;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// result word for this byte
	always_comb begin
		res.token_ready  = tok_fire;
		res.token_index  = tok_fire ? seen_q[IDX_W-1:0] : '0;
		res.token_offset = tok_fire ? (cfg.region_base + BASE_W'(rel_off)) : '0;
		res.token_length = tok_fire ? rec_len_q : '0;
		res.done_res     = (phase_d == PH_DONE);
		res.status       = (phase_d == PH_DONE) ? err_d : ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LEN_LO;
			pos_q      <= '0;
			seen_q     <= '0;
			len_lo_q   <= '0;
			rec_len_q  <= '0;
			body_cnt_q <= '0;
			lead_q     <= '0;
			good_q     <= 1'b1;
			err_q      <= ST_OK;
		end else if (clear) begin
			phase_q    <= PH_LEN_LO;
			pos_q      <= '0;
			seen_q     <= '0;
			len_lo_q   <= '0;
			rec_len_q  <= '0;
			body_cnt_q <= '0;
			lead_q     <= '0;
			good_q     <= 1'b1;
			err_q      <= ST_OK;
		end else if (step) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			seen_q     <= seen_d;
			len_lo_q   <= len_lo_d;
			rec_len_q  <= rec_len_d;
			body_cnt_q <= body_cnt_d;
			lead_q     <= lead_d;
			good_q     <= good_d;
			err_q      <= err_d;
		end
	end

endmodule

@@ hdl/utf8_token_table_checker.sv @@
// top level: apb registers, parser and output register of the utf8 token table checker
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------------------------
//  input    | in_valid / in_ready          | in_byte
//  output   | out_valid / out_ready        | token_ready token_index token_offset
//           |                              | token_length done_res status
//  config   | psel penable pwrite pready   | paddr pwdata prdata
//
// one byte a cycle while the output is not stalled: each byte is checked in the cycle it is accepted and its
// result word lands in the output register on the same edge
// in_ready stays high while the output register is empty or being drained,
// so a stalled output holds one word and stops input only after that
// reset (and any write to a defined register) returns the parser to a record start
// one result word per byte
`timescale 1ns / 1ps
`include "utf8_token_table_checker_assert.svh"
module utf8_token_table_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [utf8tc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    in_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          token_ready,
	output logic [utf8tc_pkg::IDX_W-1:0]  token_index,
	output logic [utf8tc_pkg::BASE_W-1:0] token_offset,
	output logic [utf8tc_pkg::LEN_W-1:0]  token_length,
	output logic                          done_res,
	output logic [1:0]                    status
);
	import utf8tc_pkg::*;

	cfg_t       cfg_q;
	result_t    res;
	result_t    res_q;
	logic       out_valid_q;
	logic       in_acc;
	logic       cfg_wr;
	logic       cfg_hit;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_hit = cfg_wr && (reg_idx == REG_TOKEN_COUNT || reg_idx == REG_REGION_BYTES ||
		reg_idx == REG_REGION_BASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.token_count  <= CNT_W'(1);
			cfg_q.region_bytes <= RB_W'(1);
			cfg_q.region_base  <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_TOKEN_COUNT:  cfg_q.token_count  <= pwdata[CNT_W-1:0];
				REG_REGION_BYTES: cfg_q.region_bytes <= pwdata[RB_W-1:0];
				REG_REGION_BASE:  cfg_q.region_base  <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TOKEN_COUNT:  prdata = 32'(cfg_q.token_count);
			REG_REGION_BYTES: prdata = 32'(cfg_q.region_bytes);
			REG_REGION_BASE:  prdata = cfg_q.region_base;
			default:          prdata = '0;
		endcase
	end

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	utf8tc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (in_acc),
		.clear   (cfg_hit),
		.in_byte (in_byte),
		.cfg     (cfg_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign token_ready  = res_q.token_ready;
	assign token_index  = res_q.token_index;
	assign token_offset = res_q.token_offset;
	assign token_length = res_q.token_length;
	assign done_res     = res_q.done_res;
	assign status       = res_q.status;

	`UTC_ASSERT_NEXT(a_word_follows_byte, in_acc, out_valid_q)
	`UTC_ASSERT_HOLDS(a_status_only_when_done, !out_valid_q || res_q.done_res || res_q.status == ST_OK)
	`UTC_ASSERT_HOLDS(a_token_len_range, !(out_valid_q && res_q.token_ready) || (res_q.token_length >= 3'd1 && res_q.token_length <= 3'd4))
	`UTC_ASSERT_HOLDS(a_idle_fields_zero, !(out_valid_q && !res_q.token_ready) || (res_q.token_length == '0 && res_q.token_index == '0 && res_q.token_offset == '0))

endmodule
